### hw/rtl/rhht_pkg.sv
// ----------------------------------------------------------------------------
// rhht_pkg
// Shared types, constants and command codes of the Robin Hood hash table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rhht_pkg;

	// The table size must be a power of two: the home bucket is the low hash bits.
	localparam int TABLE_SIZE = 1024;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int CNT_W      = IDX_W + 1;
	localparam int KEY_W      = 32;
	localparam int VAL_W      = 32;
	localparam int HASH_W     = 32;
	localparam int DIST_W     = IDX_W;
	localparam int PROBE_W    = 11;

	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_SET    = 2'd1;
	localparam logic [1:0] MODE_ADD    = 2'd2;
	localparam logic [1:0] MODE_DELETE = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_KEY = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	// Hash constants for a four-byte key.
	localparam logic [31:0] MUR_C1    = 32'hcc9e2d51;
	localparam logic [31:0] MUR_C2    = 32'h1b873593;
	localparam logic [31:0] MUR_N     = 32'he6546b64;
	localparam logic [31:0] FMIX_1    = 32'h85ebca6b;
	localparam logic [31:0] FMIX_2    = 32'hc2b2ae35;
	localparam logic [31:0] KEY_BYTES = 32'd4;

	typedef struct packed {
		logic [1:0]       mode;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [VAL_W-1:0]   old_value;
		logic [PROBE_W-1:0] probe_count;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
		logic [HASH_W-1:0] hash;
		logic [DIST_W-1:0] pdist;
	} entry_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_ZEROKEY,
		OP_FULL,
		OP_FIND_INIT,
		OP_READ,
		OP_READ_NEXT,
		OP_FIND_NEXT,
		OP_HIT,
		OP_SHIFT_MOVE,
		OP_SHIFT_END,
		OP_INS_INIT,
		OP_INS_STEP,
		OP_INS_PLACE,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic       hash_done;
		logic       clear_last;
		logic [1:0] mode;
		logic       key_zero;
		logic       rd_empty;
		logic       rd_match;
		logic       rd_poor;
		logic       n_last;
		logic       shift_stop;
		logic       table_full;
		logic       out_free;
	} sts_t;

endpackage

`default_nettype wire

### hw/rtl/rhht_hash.sv
// ----------------------------------------------------------------------------
// rhht_hash
// Five-stage pipelined 32-bit key hash with seed, one multiply in each stage but the last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhht_hash (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [rhht_pkg::KEY_W-1:0]     key,
	input  wire logic [31:0]                    seed,
	output logic      [rhht_pkg::HASH_W-1:0]    hash,
	output logic                                done
);
	import rhht_pkg::*;

	logic [31:0] k1_s1, k2_s2, h3_s3, h4_s4, h5_s5;
	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [31:0] k1_rot, h_a, h_b, h_c, h_d, h_e, h_f;

	always_comb begin
		k1_rot = {k1_s1[16:0], k1_s1[31:17]};
		h_a    = seed ^ k2_s2;
		h_b    = {h_a[18:0], h_a[31:19]};
		h_c    = {h_b[29:0], 2'b00} + h_b + MUR_N;
		h_d    = h_c ^ KEY_BYTES;
		h_e    = h_d ^ (h_d >> 16);
		h_f    = h3_s3 ^ (h3_s3 >> 13);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (start) k1_s1 <= 32'(key * MUR_C1);
		if (v_s1)  k2_s2 <= 32'(k1_rot * MUR_C2);
		if (v_s2)  h3_s3 <= 32'(h_e * FMIX_1);
		if (v_s3)  h4_s4 <= 32'(h_f * FMIX_2);
		if (v_s4)  h5_s5 <= h4_s4 ^ (h4_s4 >> 16);
	end

	assign hash = h5_s5;
	assign done = v_s5;

endmodule

`default_nettype wire

### hw/rtl/rhht_dp.sv
// ----------------------------------------------------------------------------
// rhht_dp
// Datapath: bucket memory, probe registers, entry count and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhht_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rhht_pkg::req_t  in_req,
	input  wire logic [31:0]     seed,
	input  wire rhht_pkg::cmd_t  cmd,
	input  wire logic            out_stall,
	output rhht_pkg::sts_t       sts,
	output logic                 out_valid,
	output rhht_pkg::rsp_t       out_rsp
);
	import rhht_pkg::*;

	entry_t mem [TABLE_SIZE];

	entry_t              rd_q, carry_q, wd;
	req_t                req_q;
	rsp_t                res_q, out_rsp_q;
	logic [IDX_W-1:0]    idx_q, at_q, idx_nxt, wa, ra;
	logic [CNT_W-1:0]    n_q, count_q;
	logic                out_valid_q, we, re, swap;
	logic [HASH_W-1:0]   hash_val;
	logic                hash_done;

	rhht_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_LOAD),
		.key    (in_req.key),
		.seed   (seed),
		.hash   (hash_val),
		.done   (hash_done)
	);

	assign idx_nxt = idx_q + 1'b1;
	assign swap    = carry_q.pdist > rd_q.pdist;

	always_comb begin
		we = 1'b0;
		wa = idx_q;
		wd = '0;
		unique case (cmd.op)
			OP_CLEAR: begin
				we = 1'b1;
			end
			OP_HIT: begin
				wd = rd_q;
				if (req_q.mode == MODE_SET) begin
					we       = 1'b1;
					wd.value = req_q.value;
				end else if (req_q.mode == MODE_ADD) begin
					we       = 1'b1;
					wd.value = rd_q.value + req_q.value;
				end
			end
			OP_SHIFT_MOVE: begin
				we       = 1'b1;
				wd       = rd_q;
				wd.pdist = rd_q.pdist - 1'b1;
			end
			OP_SHIFT_END: begin
				we = 1'b1;
			end
			OP_INS_PLACE: begin
				we = 1'b1;
				wd = carry_q;
			end
			OP_INS_STEP: begin
				we = swap;
				wd = carry_q;
			end
			default: begin
			end
		endcase
	end

	assign re = (cmd.op == OP_READ) || (cmd.op == OP_READ_NEXT);
	assign ra = (cmd.op == OP_READ_NEXT) ? idx_nxt : idx_q;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
	end

	always_ff @(posedge clk) begin
		if (re) rd_q <= mem[ra];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			n_q         <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_CLEAR, OP_FIND_NEXT, OP_SHIFT_MOVE, OP_INS_STEP: idx_q <= idx_nxt;
				OP_FIND_INIT, OP_INS_INIT: idx_q <= hash_val[IDX_W-1:0];
				default: begin
				end
			endcase
			if (cmd.op == OP_FIND_INIT) begin
				n_q <= '0;
			end else if (cmd.op == OP_FIND_NEXT) begin
				n_q <= n_q + 1'b1;
			end
			if (cmd.op == OP_HIT && req_q.mode == MODE_DELETE) begin
				count_q <= count_q - 1'b1;
			end else if (cmd.op == OP_INS_PLACE) begin
				count_q <= count_q + 1'b1;
			end
			priority if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				req_q <= in_req;
				res_q <= '0;
			end
			OP_ZEROKEY: res_q.status <= ST_ZERO_KEY;
			OP_FULL:    res_q.status <= ST_FULL;
			OP_HIT: begin
				at_q            <= idx_q;
				res_q.found     <= 1'b1;
				res_q.old_value <= rd_q.value;
			end
			OP_INS_INIT: begin
				carry_q.key   <= req_q.key;
				carry_q.value <= req_q.value;
				carry_q.hash  <= hash_val;
				carry_q.pdist <= '0;
			end
			OP_INS_STEP: begin
				if (swap) begin
					carry_q.key   <= rd_q.key;
					carry_q.value <= rd_q.value;
					carry_q.hash  <= rd_q.hash;
					carry_q.pdist <= rd_q.pdist + 1'b1;
				end else begin
					carry_q.pdist <= carry_q.pdist + 1'b1;
				end
				res_q.probe_count <= res_q.probe_count + 1'b1;
			end
			OP_EMIT: out_rsp_q <= res_q;
			default: begin
			end
		endcase
	end

	always_comb begin
		sts.hash_done  = hash_done;
		sts.clear_last = idx_q == IDX_W'(TABLE_SIZE - 1);
		sts.mode       = req_q.mode;
		sts.key_zero   = req_q.key == '0;
		sts.rd_empty   = rd_q.key == '0;
		sts.rd_match   = (rd_q.key == req_q.key) && (rd_q.hash == hash_val);
		sts.rd_poor    = n_q > {1'b0, rd_q.pdist};
		sts.n_last     = n_q == CNT_W'(TABLE_SIZE - 1);
		sts.shift_stop = (idx_nxt == at_q) || (rd_q.key == '0) || (rd_q.pdist == '0);
		sts.table_full = count_q >= CNT_W'(TABLE_SIZE);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

endmodule

`default_nettype wire

### hw/rtl/rhht_ctrl.sv
// ----------------------------------------------------------------------------
// rhht_ctrl
// Controller: sequences clearing, hashing, probing, shifting and insertion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhht_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire rhht_pkg::sts_t  sts,
	output logic                 busy,
	output rhht_pkg::cmd_t       cmd
);
	import rhht_pkg::*;

	typedef enum logic [9:0] {
		S_CLEAR = 10'b00_0000_0001,
		S_IDLE  = 10'b00_0000_0010,
		S_HASH  = 10'b00_0000_0100,
		S_FREAD = 10'b00_0000_1000,
		S_FCHK  = 10'b00_0001_0000,
		S_SREAD = 10'b00_0010_0000,
		S_SCHK  = 10'b00_0100_0000,
		S_IREAD = 10'b00_1000_0000,
		S_ICHK  = 10'b01_0000_0000,
		S_DONE  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   miss, is_put;

	assign is_put = (sts.mode == MODE_SET) || (sts.mode == MODE_ADD);

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		miss    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (sts.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				if (sts.hash_done) begin
					if (sts.key_zero) begin
						if (is_put) cmd.op = OP_ZEROKEY;
						state_d = S_DONE;
					end else begin
						cmd.op  = OP_FIND_INIT;
						state_d = S_FREAD;
					end
				end
			end
			S_FREAD: begin
				cmd.op  = OP_READ;
				state_d = S_FCHK;
			end
			S_FCHK: begin
				priority if (sts.rd_empty || sts.rd_poor) begin
					miss = 1'b1;
				end else if (sts.rd_match) begin
					cmd.op  = OP_HIT;
					state_d = (sts.mode == MODE_DELETE) ? S_SREAD : S_DONE;
				end else if (sts.n_last) begin
					miss = 1'b1;
				end else begin
					cmd.op  = OP_FIND_NEXT;
					state_d = S_FREAD;
				end
			end
			S_SREAD: begin
				cmd.op  = OP_READ_NEXT;
				state_d = S_SCHK;
			end
			S_SCHK: begin
				if (sts.shift_stop) begin
					cmd.op  = OP_SHIFT_END;
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_SHIFT_MOVE;
					state_d = S_SREAD;
				end
			end
			S_IREAD: begin
				cmd.op  = OP_READ;
				state_d = S_ICHK;
			end
			S_ICHK: begin
				if (sts.rd_empty) begin
					cmd.op  = OP_INS_PLACE;
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_INS_STEP;
					state_d = S_IREAD;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (miss) begin
			if (!is_put) begin
				state_d = S_DONE;
			end else if (sts.table_full) begin
				cmd.op  = OP_FULL;
				state_d = S_DONE;
			end else begin
				cmd.op  = OP_INS_INIT;
				state_d = S_IREAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

`default_nettype wire

### hw/rtl/robin_hood_hash_table.sv
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// A request is hashed after acceptance, then each bucket probed, shifted or displaced
// costs a read state and a check state on the bucket memory before a valid result.
// Requests are handled one at a time, the next taken at the earliest in the cycle after
// the result is registered; a finished result waits in the output
// register while the next request is taken. Reset: after arst_n releases, a clearing
// pass writes all TABLE_SIZE (1024) buckets, one per cycle, with stall high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module robin_hood_hash_table (
	input  wire logic            clk,
	input  wire logic            arst_n,
	// Request channel.
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire rhht_pkg::req_t  in_req,
	// Result channel.
	output logic                 out_valid,
	input  wire logic            out_stall,
	output rhht_pkg::rsp_t       out_rsp,
	// Seed register write channel.
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [31:0]     cfg_data
);
	import rhht_pkg::*;

	// The seed register is always writable; writes should only happen while idle, which the block does not enforce.
	logic [31:0] seed_q;
	cmd_t        cmd;
	sts_t        sts;
	logic        busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= cfg_data;
		end
	end

	// The controller walks the buckets; the datapath holds the table and
	// carries the entry being moved during insertion and deletion.
	rhht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd)
	);

	rhht_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_req    (in_req),
		.seed      (seed_q),
		.cmd       (cmd),
		.out_stall (out_stall),
		.sts       (sts),
		.out_valid (out_valid),
		.out_rsp   (out_rsp)
	);

	// A request is only taken when the controller is idle.
	assign in_stall = busy;

	// After a request is taken the block stays busy until its result is out.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken but block not busy");

	// No request is taken during the clearing pass.
	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_CLEAR |-> in_stall)
		else $error("request channel open during clearing pass");

	// A new result never overwrites one that has not been taken.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |-> sts.out_free)
		else $error("result register overwritten");

endmodule

`default_nettype wire
